### hw/rtl/srgb_enc_pkg.sv
// ----------------------------------------------------------------------------
// srgb_enc_pkg
// Shared widths, stage-enable type and the knot-table builder for the sRGB
// gamma encoder.
// ----------------------------------------------------------------------------
package srgb_enc_pkg;

    // fixed field widths
    localparam int IN_W      = 20;
    localparam int ENC_W     = 8;

    // knot values: 255 * g(t), signed, 20 fraction bits
    localparam int KNOT_W    = 30;
    localparam int KNOT_FRAC = 20;

    // defaults for the top-level parameters
    localparam int DEF_FRAC_BITS      = 16;
    localparam int DEF_CURVE_SEGMENTS = 64;

    // 255 * 12.92 * 10, linear segment gain
    localparam int LIN_GAIN_W = 16;
    localparam logic [LIN_GAIN_W-1:0] LIN_GAIN = 16'd32946;

    // per-stage load enables, shared by all channel lanes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } srgb_enc_stage_en_t;

    // integer square root, bit by bit (elaboration only)
    function automatic logic [63:0] root2(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bitv > n) bitv = bitv >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 64'd0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // integer cube root, binary search (elaboration only)
    function automatic logic [63:0] root3(input logic [63:0] n);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = '0;
        hi = (64'd1 << 21) - 64'd1;
        for (int k = 0; k < 24; k++) begin
            if (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                if (mid * mid * mid <= n) lo = mid;
                else hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

    // knot value for a Q30 position t: 255 * (1.055 * t^(5/12) - 0.055), Q20
    function automatic longint knot_from_t(input logic [63:0] t);
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] c;
        longint      p;
        longint      g;
        s = root2(t << 30);
        q = root2(s << 30);
        c = root3((s >> 10) << 40);
        p = longint'((q * c) >> 20);
        g = 64'sd1055 * p - (64'sd55 <<< 30);
        return (64'sd255 * g) / 64'sd1024000;
    endfunction

endpackage

### hw/rtl/srgb_gamma_encode_pixel_core.sv
// ----------------------------------------------------------------------------
// srgb_gamma_encode_pixel_core
// sRGB gamma encoder: linear RGB pixels in, 8-bit encoded BGR pixels out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                              | tlast
//  ---------+-----+------------------------------------+-----------
//  s_       | in  | lin_red, lin_green, lin_blue (20b) | last_pixel
//  m_       | out | enc_blue, enc_green, enc_red (8b)  | last_out
//
//  one pixel per clock while m_tready does not stall; each pixel passes through
//  the four register stages of each channel lane
//  aresetn (synchronous, active low) clears the stage valid bits only
//  a stall on m_tready holds the full stages; empty stages keep filling
//
module srgb_gamma_encode_pixel_core
    import srgb_enc_pkg::*;
#(
    parameter int FRAC_BITS      = DEF_FRAC_BITS,
    parameter int CURVE_SEGMENTS = DEF_CURVE_SEGMENTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lin_red[19:0], lin_green[39:20], lin_blue[59:40], zeros
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // enc_blue[7:0], enc_green[15:8], enc_red[23:16]
    output logic        m_tlast
);

    localparam int STAGES = 4;

    logic [STAGES-1:0]  valid_reg, valid_next;
    logic [STAGES-1:0]  last_reg, last_next;
    logic [STAGES-1:0]  en;
    srgb_enc_stage_en_t stage_en;
    logic [ENC_W-1:0]   enc_red, enc_green, enc_blue;

    // stage enables: a stage loads when empty or when the next one loads
    always_comb begin
        en[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        stage_en.s1 = en[0];
        stage_en.s2 = en[1];
        stage_en.s3 = en[2];
        stage_en.s4 = en[3];
    end

    // valid and last travel with the data
    always_comb begin
        valid_next = valid_reg;
        last_next  = last_reg;
        if (en[0]) begin
            valid_next[0] = s_tvalid;
            last_next[0]  = s_tlast;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
                valid_next[k] = valid_reg[k-1];
                last_next[k]  = last_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
        last_reg <= last_next;
    end

    // channel lanes
    srgb_enc_lane #(
        .FRAC_BITS      (FRAC_BITS),
        .CURVE_SEGMENTS (CURVE_SEGMENTS)
    ) u_lane_red (
        .aclk     (aclk),
        .stage_en (stage_en),
        .lin_raw  (s_tdata[IN_W-1:0]),
        .enc_out  (enc_red)
    );

    srgb_enc_lane #(
        .FRAC_BITS      (FRAC_BITS),
        .CURVE_SEGMENTS (CURVE_SEGMENTS)
    ) u_lane_green (
        .aclk     (aclk),
        .stage_en (stage_en),
        .lin_raw  (s_tdata[2*IN_W-1:IN_W]),
        .enc_out  (enc_green)
    );

    srgb_enc_lane #(
        .FRAC_BITS      (FRAC_BITS),
        .CURVE_SEGMENTS (CURVE_SEGMENTS)
    ) u_lane_blue (
        .aclk     (aclk),
        .stage_en (stage_en),
        .lin_raw  (s_tdata[3*IN_W-1:2*IN_W]),
        .enc_out  (enc_blue)
    );

    // output channel
    assign s_tready = en[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tlast  = last_reg[STAGES-1];
    assign m_tdata  = {enc_red, enc_green, enc_blue};

    // an empty output stage never blocks the input
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[STAGES-1] |-> s_tready)
        else $error("input stalled with empty output stage");

    // an accepted request lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted request lost at stage one");

    // a held middle stage keeps its item and flag
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[2] && !en[2]) |=> (valid_reg[2] && $stable(last_reg[2])))
        else $error("stalled stage dropped its request");

endmodule

### hw/rtl/srgb_enc_lane.sv
// ----------------------------------------------------------------------------
// srgb_enc_lane
// One color channel of the encoder: four-stage pipeline from a linear
// fixed-point sample to an 8-bit gamma-encoded code.
// ----------------------------------------------------------------------------
module srgb_enc_lane
    import srgb_enc_pkg::*;
#(
    parameter int FRAC_BITS      = DEF_FRAC_BITS,
    parameter int CURVE_SEGMENTS = DEF_CURVE_SEGMENTS
) (
    input  logic               aclk,
    input  srgb_enc_stage_en_t stage_en,
    input  logic [IN_W-1:0]    lin_raw,
    output logic [ENC_W-1:0]   enc_out
);

    localparam int IDX_W    = $clog2(CURVE_SEGMENTS + 1);
    localparam int POS_W    = FRAC_BITS + IDX_W;
    localparam int FULL_W   = IN_W + POS_W;
    localparam int LPROD_W  = IN_W + LIN_GAIN_W;
    localparam int LSUM_W   = LPROD_W + 1;
    localparam int PROD_W   = KNOT_W + FRAC_BITS;
    localparam logic [63:0] LIN_LIMIT = (64'd31308 << FRAC_BITS) / 64'd10000000;
    localparam logic [63:0] ONE_RAW   = 64'd1 << FRAC_BITS;
    localparam logic [LSUM_W-1:0] LIN_HALF = LSUM_W'(64'd5 << FRAC_BITS);

    // knot table, built at elaboration
    logic signed [KNOT_W-1:0] knot_tab [CURVE_SEGMENTS+1];
    for (genvar gi = 0; gi <= CURVE_SEGMENTS; gi++) begin : g_knot
        localparam logic [63:0] KnotT = (64'(gi) << 30) / CURVE_SEGMENTS;
        assign knot_tab[gi] = KNOT_W'(knot_from_t(KnotT));
    end

    // stage 1: range flags, segment position, linear product
    logic                lin1_reg, lin1_next;
    logic                big1_reg, big1_next;
    logic [POS_W-1:0]    pos1_reg, pos1_next;
    logic [LPROD_W-1:0]  lprod1_reg, lprod1_next;
    logic [FULL_W-1:0]   pos_full;

    always_comb begin
        lin1_next   = 64'(lin_raw) <= LIN_LIMIT;
        big1_next   = 64'(lin_raw) >= ONE_RAW;
        pos_full    = FULL_W'(lin_raw) * FULL_W'(CURVE_SEGMENTS);
        pos1_next   = big1_next ? '0 : pos_full[POS_W-1:0];
        lprod1_next = LPROD_W'(lin_raw) * LPROD_W'(LIN_GAIN);
    end

    always_ff @(posedge aclk) begin
        if (stage_en.s1) begin
            lin1_reg   <= lin1_next;
            big1_reg   <= big1_next;
            pos1_reg   <= pos1_next;
            lprod1_reg <= lprod1_next;
        end
    end

    // stage 2: knot lookup, linear rounding and divide by ten
    logic                     lin2_reg, big2_reg;
    logic signed [KNOT_W-1:0] k0_2_reg, k0_2_next;
    logic signed [KNOT_W-1:0] k1_2_reg, k1_2_next;
    logic [FRAC_BITS-1:0]     frac2_reg, frac2_next;
    logic [ENC_W-1:0]         lres2_reg, lres2_next;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         idx_up;
    logic [LSUM_W-1:0]        lsum;
    logic [7:0]               lquo;
    logic [15:0]              ldiv;

    always_comb begin
        idx        = pos1_reg[FRAC_BITS +: IDX_W];
        idx_up     = IDX_W'(idx + 1'b1);
        k0_2_next  = knot_tab[idx];
        k1_2_next  = knot_tab[idx_up];
        frac2_next = pos1_reg[FRAC_BITS-1:0];
        // q / 10 == (q * 205) >> 11 for small q
        lsum       = LSUM_W'(lprod1_reg) + LIN_HALF;
        lquo       = lsum[FRAC_BITS +: 8];
        ldiv       = 16'(lquo) * 16'd205;
        lres2_next = ENC_W'(ldiv[15:11]);
    end

    always_ff @(posedge aclk) begin
        if (stage_en.s2) begin
            lin2_reg  <= lin1_reg;
            big2_reg  <= big1_reg;
            k0_2_reg  <= k0_2_next;
            k1_2_reg  <= k1_2_next;
            frac2_reg <= frac2_next;
            lres2_reg <= lres2_next;
        end
    end

    // stage 3: segment slope times fraction
    logic                     lin3_reg, big3_reg;
    logic signed [KNOT_W-1:0] k0_3_reg;
    logic [ENC_W-1:0]         lres3_reg;
    logic [PROD_W-1:0]        prod3_reg, prod3_next;
    logic [KNOT_W-1:0]        slope;

    always_comb begin
        slope      = KNOT_W'(k1_2_reg - k0_2_reg);
        prod3_next = PROD_W'(slope) * PROD_W'(frac2_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en.s3) begin
            lin3_reg  <= lin2_reg;
            big3_reg  <= big2_reg;
            k0_3_reg  <= k0_2_reg;
            lres3_reg <= lres2_reg;
            prod3_reg <= prod3_next;
        end
    end

    // stage 4: add, round half up, saturate, pick segment
    logic [ENC_W-1:0]         enc4_reg, enc4_next;
    logic [KNOT_W-1:0]        step;
    logic signed [KNOT_W:0]   val;
    logic signed [KNOT_W:0]   rnd;
    logic [KNOT_W-KNOT_FRAC-1:0] rounded;
    logic [ENC_W-1:0]         curve;

    always_comb begin
        step    = prod3_reg[FRAC_BITS +: KNOT_W];
        val     = {k0_3_reg[KNOT_W-1], k0_3_reg} + $signed({1'b0, step});
        rnd     = val + $signed((KNOT_W+1)'(1) <<< (KNOT_FRAC - 1));
        rounded = rnd[KNOT_W-1:KNOT_FRAC];
        if (val < 0) begin
            curve = '0;
        end else if (rounded > (KNOT_W-KNOT_FRAC)'(255)) begin
            curve = '1;
        end else begin
            curve = rounded[ENC_W-1:0];
        end
        if (lin3_reg) begin
            enc4_next = lres3_reg;
        end else if (big3_reg) begin
            enc4_next = '1;
        end else begin
            enc4_next = curve;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.s4) begin
            enc4_reg <= enc4_next;
        end
    end

    assign enc_out = enc4_reg;

endmodule
